// File: sv/dwtdv_pkg.sv
// ----------------------------------------------------------------------------
// DWT data-value packet parser package
// Item types, parse state, header decode constants and helpers.
// ----------------------------------------------------------------------------
package dwtdv_pkg;

  localparam int unsigned PosWidth    = 32;
  localparam int unsigned HdrPosWidth = (PosWidth < 32) ? PosWidth : 32;

  localparam logic [7:0] SizeMask      = 8'h03;
  localparam logic [7:0] KindMask      = 8'hC0;
  localparam logic [7:0] DataValueKind = 8'h80;
  localparam logic [7:0] HwSourceBit   = 8'h04;
  localparam logic [7:0] WriteBit      = 8'h08;
  localparam logic [7:0] ContMask      = 8'hCF;
  localparam logic [7:0] ContHeader    = 8'hC0;

  localparam logic [1:0] SizeCodeOne  = 2'd1;
  localparam logic [1:0] SizeCodeTwo  = 2'd2;
  localparam logic [1:0] SizeCodeFour = 2'd3;

  typedef enum logic [1:0] {
    ModeHeader  = 2'd0,
    ModePayload = 2'd1,
    ModeCont    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0]  trace_byte;
    logic [31:0] byte_pos;
  } in_item_t;

  typedef struct packed {
    logic [31:0] event_pos;
    logic [1:0]  comparator_id;
    logic [2:0]  payload_size;
    logic [31:0] data_value;
  } out_item_t;

  typedef struct packed {
    mode_e                  mode;
    logic [2:0]             bytes_left;
    logic [31:0]            value_accum;
    logic [7:0]             held_header;
    logic [HdrPosWidth-1:0] header_pos;
    logic [2:0]             byte_count;
  } parse_state_t;

  // Payload length in bytes for a header, zero when not a source header.
  function automatic logic [2:0] size_bytes(logic [7:0] hdr);
    logic [2:0] n;
    case (hdr[1:0] & SizeMask[1:0])
      SizeCodeOne:  n = 3'd1;
      SizeCodeTwo:  n = 3'd2;
      SizeCodeFour: n = 3'd4;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_data_value_write(logic [7:0] hdr);
    return ((hdr & KindMask) == DataValueKind) && ((hdr & HwSourceBit) != 8'h00) &&
           ((hdr & WriteBit) != 8'h00);
  endfunction

endpackage

// File: sv/dwtdv_framer.sv
// ----------------------------------------------------------------------------
// DWT data-value packet framer step
// Next parse state and optional result for one trace byte.
// ----------------------------------------------------------------------------
module dwtdv_framer import dwtdv_pkg::*; (
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  output parse_state_t state_o,
  output logic         res_valid_o,
  output out_item_t    res_o
);

  logic [7:0]  b;
  logic [31:0] shifted;
  logic [2:0]  hdr_size;

  assign b        = item_i.trace_byte;
  assign shifted  = {24'h000000, b} << {state_i.byte_count[1:0], 3'b000};
  assign hdr_size = size_bytes(b);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.event_pos     = 32'(state_i.header_pos);
    res_o.comparator_id = state_i.held_header[5:4];
    res_o.payload_size  = size_bytes(state_i.held_header);
    res_o.data_value    = state_i.value_accum | shifted;

    case (state_i.mode)
      ModePayload: begin
        state_o.value_accum = state_i.value_accum | shifted;
        state_o.byte_count  = 3'(state_i.byte_count + 3'd1);
        state_o.bytes_left  = 3'(state_i.bytes_left - 3'd1);
        // last payload byte: counter reaches zero
        if (state_i.bytes_left == 3'd1) begin
          state_o.mode = ModeHeader;
          res_valid_o  = is_data_value_write(state_i.held_header);
        end
      end
      ModeCont: begin
        if (!b[7]) begin
          state_o.mode = ModeHeader;
        end
      end
      default: begin
        if (hdr_size != 3'd0) begin
          state_o.held_header = b;
          state_o.header_pos  = item_i.byte_pos[HdrPosWidth-1:0];
          state_o.bytes_left  = hdr_size;
          state_o.byte_count  = 3'd0;
          state_o.value_accum = 32'd0;
          state_o.mode        = ModePayload;
        end else if ((b & ContMask) == ContHeader) begin
          state_o.mode = ModeCont;
        end else begin
          state_o.mode = ModeHeader;
        end
      end
    endcase
  end

endmodule

// File: sv/dwt_data_value_packet_parser.sv
// ----------------------------------------------------------------------------
// DWT data-value packet parser
// Frames software-trace packets and reports data-value write packets.
// ----------------------------------------------------------------------------
// Input channel: one trace byte with its stream position per item, taken
// when in_valid_i is high and in_stall_o is low. The byte is decoded in the
// cycle it arrives and updates the framing state at that edge.
// Output channel: one item per completed data-value write packet (header
// position, comparator id, size 1/2/4, little-endian value), offered from
// a result register in the cycle after the last payload byte is taken. Other
// packets, continuation runs and protocol bytes produce no item.
// Throughput: one byte per cycle while in_stall_o is low.
// Stall: in_stall_o rises only while a result waits and out_stall_i is
// high, since the next byte might finish another packet; a result being
// taken in the same cycle frees the register for the next one.
// Reset: framing returns to expecting a header, no result is pending.
// ----------------------------------------------------------------------------
module dwt_data_value_packet_parser import dwtdv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  parse_state_t state_q, state_d;
  logic         res_valid;
  out_item_t    res;
  logic         out_valid_q;
  out_item_t    out_item_q;
  logic         in_acc;

  dwtdv_framer u_framer (
    .state_i     (state_q),
    .item_i      (in_item_i),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: ModeHeader, bytes_left: 3'd0, value_accum: 32'd0,
                   held_header: 8'd0, header_pos: '0, byte_count: 3'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (in_acc && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: load on a finished data-value packet
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_item_q <= res;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == ModePayload |-> state_q.bytes_left != 3'd0)
    else $error("payload mode with no bytes left");

  a_result_on_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid |-> state_q.mode == ModePayload && state_q.bytes_left == 3'd1)
    else $error("result outside the last payload byte");

  a_size_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.payload_size == 3'd1 || out_item_o.payload_size == 3'd2 ||
                    out_item_o.payload_size == 3'd4)
    else $error("illegal payload size");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty result register");

endmodule
